/* design/a2yuv_pkg.sv */
// ----------------------------------------------------------------------------
// a2yuv_pkg: shared types and constants for the RGB to YUV 4:2:0 stream
// Word layouts for the pixel and result channels, the register map and the
// fixed field widths used by every module of the converter.
// ----------------------------------------------------------------------------
package a2yuv_pkg;

    localparam int LUMA_W   = 24;  // raster pixel offset, wraps at 24 bits
    localparam int CHROMA_W = 23;  // chroma pair count, wraps at 23 bits
    localparam int ADDR_W   = 25;  // byte address width
    localparam int SIZE_W   = 26;  // luma plane size W*H
    localparam int DIM_W    = 13;  // effective width and height

    localparam int APB_ADDR_W = 4;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_HALF_WIDTH   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SEMI_PLANAR  = 2'd2;

    localparam logic [11:0] RST_HALF_WIDTH   = 12'd320;
    localparam logic [12:0] RST_FRAME_HEIGHT = 13'd480;

    localparam logic [1:0] PLANE_Y = 2'd0;
    localparam logic [1:0] PLANE_U = 2'd1;
    localparam logic [1:0] PLANE_V = 2'd2;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [1:0]        plane;
        logic [ADDR_W-1:0] byte_address;
        logic [7:0]        sample;
        logic              last;
        logic              frame_end;
    } t_result;

    typedef struct packed {
        logic [11:0] half_width;
        logic [12:0] frame_height;
        logic        semi_planar;
    } t_cfg;

    // One pixel after position tracking, waiting for conversion.
    typedef struct packed {
        t_pixel              pix;
        logic [LUMA_W-1:0]   luma_idx;
        logic [CHROMA_W-1:0] chroma_idx;
        logic                chroma;
        logic                frame_last;
    } t_stage;

endpackage

/* design/argb_to_yuv420_stream.sv */
// ----------------------------------------------------------------------------
// argb_to_yuv420_stream: streaming RGB to YUV 4:2:0 converter
// Converts raster-order pixels into addressed luma and chroma bytes.
// ----------------------------------------------------------------------------
// Each accepted pixel word produces a luma word and, for a pixel in an even
// column of an even row, a U word and a V word after it, all on one output
// channel that moves one word per cycle while the output is not stalled. A
// pixel thus fills one output word, or three when it carries chroma; the
// output port is the only limit on rate. A pixel is held in the input
// register and then in the output register before its first word is
// presented. Pixels are tracked against the frame geometry in force when
// they are accepted; the luma plane size is registered from the geometry
// registers every cycle, so registers should be written while the stream
// is idle. Width is programmed as half the image width.
module argb_to_yuv420_stream #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Pixel input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  a2yuv_pkg::t_pixel                   i_pixel,
    // Result output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output a2yuv_pkg::t_result                  o_result,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [a2yuv_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import a2yuv_pkg::*;

    t_cfg              cfg;
    t_stage            s1;
    logic              s1_valid;
    logic              take;
    logic [SIZE_W-1:0] size;
    logic              out_fire;

    a2yuv_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Input register with column, row and plane offset tracking.
    a2yuv_pos #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_pos (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_pixel    (i_pixel),
        .i_take     (take),
        .o_s1_valid (s1_valid),
        .o_s1       (s1),
        .o_size     (size)
    );

    // Conversion and the output register that drains one word per cycle when the output is not stalled.
    a2yuv_conv u_conv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1_valid  (s1_valid),
        .i_s1        (s1),
        .i_size      (size),
        .i_semi      (cfg.semi_planar),
        .o_take      (take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (o_result)
    );

    assign out_fire = o_out_valid && !i_out_stall;

    // A pixel's words leave back to back: after a word that is not its last,
    // the next word is ready in the following cycle.
    a_burst_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && !o_result.last |=> o_out_valid)
        else $error("output gap inside one pixel's words");

    // U is always followed by V.
    a_u_then_v: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && (o_result.plane == PLANE_U) |=> o_result.plane == PLANE_V)
        else $error("U word not followed by V");

    // V always closes a pixel, and U never does.
    a_v_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_result.plane == PLANE_V) != o_result.last)
        |-> o_result.plane == PLANE_Y)
        else $error("last flag does not match the chroma word");

    // The frame end flag is the same on every word of one pixel.
    a_frame_end_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && !o_result.last |=> o_result.frame_end == $past(o_result.frame_end))
        else $error("frame end flag changed within one pixel");

endmodule

/* design/a2yuv_regs.sv */
// ----------------------------------------------------------------------------
// a2yuv_regs: configuration register file
// APB-style slave holding half width, frame height and the chroma layout.
// ----------------------------------------------------------------------------
module a2yuv_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [a2yuv_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    output a2yuv_pkg::t_cfg                     o_cfg
);
    import a2yuv_pkg::*;

    t_cfg                 r_cfg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[APB_ADDR_W-1:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_width   <= RST_HALF_WIDTH;
            r_cfg.frame_height <= RST_FRAME_HEIGHT;
            r_cfg.semi_planar  <= 1'b0;
        end else if (wr_en) begin
            case (idx)
                REG_HALF_WIDTH:   r_cfg.half_width   <= pwdata[11:0];
                REG_FRAME_HEIGHT: r_cfg.frame_height <= pwdata[12:0];
                REG_SEMI_PLANAR:  r_cfg.semi_planar  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_HALF_WIDTH:   prdata = {20'd0, r_cfg.half_width};
            REG_FRAME_HEIGHT: prdata = {19'd0, r_cfg.frame_height};
            REG_SEMI_PLANAR:  prdata = {31'd0, r_cfg.semi_planar};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

/* design/a2yuv_pos.sv */
// ----------------------------------------------------------------------------
// a2yuv_pos: frame position tracking and input register
// Clamps the frame geometry, follows column, row and plane offsets, and
// holds one accepted pixel until the conversion stage takes it.
// ----------------------------------------------------------------------------
module a2yuv_pos #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  a2yuv_pkg::t_cfg                 i_cfg,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  a2yuv_pkg::t_pixel               i_pixel,
    input  logic                            i_take,
    output logic                            o_s1_valid,
    output a2yuv_pkg::t_stage               o_s1,
    output logic [a2yuv_pkg::SIZE_W-1:0]    o_size
);
    import a2yuv_pkg::*;

    localparam int WCAP_EVEN = (MAX_WIDTH / 2) * 2;
    localparam int WCAP      = (WCAP_EVEN < 2) ? 2 : WCAP_EVEN;
    localparam int HCAP      = (MAX_HEIGHT < 1) ? 1 : MAX_HEIGHT;
    localparam int COL_W     = (WCAP > 2) ? $clog2(WCAP) : 1;
    localparam int ROW_W     = (HCAP > 1) ? $clog2(HCAP) : 1;

    logic [DIM_W-1:0]    hw2, w_eff, h0, h_eff;
    logic [COL_W-1:0]    r_col;
    logic [ROW_W-1:0]    r_row;
    logic [LUMA_W-1:0]   r_luma;
    logic [CHROMA_W-1:0] r_chroma;
    logic                r_valid;
    t_stage              r_s1;
    logic [SIZE_W-1:0]   r_size;
    logic                accept, row_end, frame_last, chroma;

    // Zero means one pair or one row; oversize values clamp to the caps.
    assign hw2   = (i_cfg.half_width == 12'd0) ? DIM_W'(2) : {i_cfg.half_width, 1'b0};
    assign w_eff = ({1'b0, hw2} > 14'(WCAP)) ? DIM_W'(WCAP) : hw2;
    assign h0    = (i_cfg.frame_height == 13'd0) ? DIM_W'(1) : i_cfg.frame_height;
    assign h_eff = ({1'b0, h0} > 14'(HCAP)) ? DIM_W'(HCAP) : h0;

    assign row_end    = (14'(r_col) + 14'd1) >= {1'b0, w_eff};
    assign frame_last = row_end && ((14'(r_row) + 14'd1) >= {1'b0, h_eff});
    assign chroma     = !r_row[0] && !r_col[0];

    assign o_in_stall = r_valid && !i_take;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_s1_valid = r_valid;
    assign o_s1       = r_s1;
    assign o_size     = r_size;

    always_ff @(posedge i_clk) begin
        r_size <= SIZE_W'(w_eff) * SIZE_W'(h_eff);
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.pix        <= i_pixel;
            r_s1.luma_idx   <= r_luma;
            r_s1.chroma_idx <= r_chroma;
            r_s1.chroma     <= chroma;
            r_s1.frame_last <= frame_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_col    <= '0;
            r_row    <= '0;
            r_luma   <= '0;
            r_chroma <= '0;
        end else begin
            if (accept) begin
                r_valid <= 1'b1;
            end else if (i_take) begin
                r_valid <= 1'b0;
            end
            if (accept) begin
                if (frame_last) begin
                    r_col    <= '0;
                    r_row    <= '0;
                    r_luma   <= '0;
                    r_chroma <= '0;
                end else begin
                    r_luma <= r_luma + LUMA_W'(1);
                    if (chroma) begin
                        r_chroma <= r_chroma + CHROMA_W'(1);
                    end
                    if (row_end) begin
                        r_col <= '0;
                        r_row <= r_row + ROW_W'(1);
                    end else begin
                        r_col <= r_col + COL_W'(1);
                    end
                end
            end
        end
    end

endmodule

/* design/a2yuv_conv.sv */
// ----------------------------------------------------------------------------
// a2yuv_conv: color conversion and result queue
// Computes luma, chroma and their byte addresses for one pixel and emits
// them one word per cycle, while the output is not stalled, from a three-entry output register.
// ----------------------------------------------------------------------------
module a2yuv_conv (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s1_valid,
    input  a2yuv_pkg::t_stage               i_s1,
    input  logic [a2yuv_pkg::SIZE_W-1:0]    i_size,
    input  logic                            i_semi,
    output logic                            o_take,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output a2yuv_pkg::t_result              o_result
);
    import a2yuv_pkg::*;

    t_result           r_q [3];
    logic [1:0]        r_cnt;
    logic              pop, free;
    logic [15:0]       r16, g16, b16, ysum, usum, vsum;
    logic [ADDR_W-1:0] size_a, qtr_a, c_a, u_addr, v_addr;
    t_result           y_res, u_res, v_res;

    assign pop         = (r_cnt != 2'd0) && !i_out_stall;
    assign free        = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop);
    assign o_take      = free && i_s1_valid;
    assign o_out_valid = r_cnt != 2'd0;
    assign o_result    = r_q[0];

    // Modular 16-bit sums: bits 15:8 are the floor of the value over 256.
    assign r16  = {8'd0, i_s1.pix.red};
    assign g16  = {8'd0, i_s1.pix.green};
    assign b16  = {8'd0, i_s1.pix.blue};
    assign ysum = 16'd66 * r16 + 16'd129 * g16 + 16'd25 * b16;
    assign usum = 16'd112 * b16 - 16'd38 * r16 - 16'd74 * g16;
    assign vsum = 16'd112 * r16 - 16'd94 * g16 - 16'd18 * b16;

    assign size_a = i_size[ADDR_W-1:0];
    assign qtr_a  = ADDR_W'(i_size[SIZE_W-1:2]);
    assign c_a    = ADDR_W'(i_s1.chroma_idx);
    assign u_addr = i_semi ? (size_a + {c_a[ADDR_W-2:0], 1'b0}) : (size_a + c_a);
    assign v_addr = i_semi ? (u_addr + ADDR_W'(1)) : (size_a + qtr_a + c_a);

    always_comb begin
        y_res.plane        = PLANE_Y;
        y_res.byte_address = ADDR_W'(i_s1.luma_idx);
        y_res.sample       = ysum[15:8] + 8'd16;
        y_res.last         = !i_s1.chroma;
        y_res.frame_end    = i_s1.frame_last;
        u_res.plane        = PLANE_U;
        u_res.byte_address = u_addr;
        u_res.sample       = usum[15:8] + 8'd128;
        u_res.last         = 1'b0;
        u_res.frame_end    = i_s1.frame_last;
        v_res.plane        = PLANE_V;
        v_res.byte_address = v_addr;
        v_res.sample       = vsum[15:8] + 8'd128;
        v_res.last         = 1'b1;
        v_res.frame_end    = i_s1.frame_last;
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_q[0] <= y_res;
            r_q[1] <= u_res;
            r_q[2] <= v_res;
        end else if (pop) begin
            r_q[0] <= r_q[1];
            r_q[1] <= r_q[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (o_take) begin
            r_cnt <= i_s1.chroma ? 2'd3 : 2'd1;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

endmodule
